FILE: src/assert_macros.svh
// Assertion helpers for the RTL. They compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MSTAM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
`define MSTAM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: assertion failed");
`else
`define MSTAM_ASSERT(label, clk, rst_n, prop)
`define MSTAM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: src/mstam_pkg.sv
`default_nettype none
package mstam_pkg;

  localparam int LOG2_LEAVES = 10;
  localparam int LEAVES      = 1 << LOG2_LEAVES;
  localparam int NODES       = 2 * LEAVES;
  localparam int NODE_W      = LOG2_LEAVES + 1;
  localparam int BOUND_W     = LOG2_LEAVES + 2;
  localparam int POS_W       = 10;
  localparam int VAL_W       = 32;
  localparam int OP_W        = 2;
  localparam int END_W       = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
  } node_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
    logic [BOUND_W-1:0]      lo;
    logic [BOUND_W-1:0]      hi;
    logic                    pos_ok;
    logic                    empty;
  } cmd_t;

  typedef struct packed {
    logic init;
    logic idle;
    logic take;
  } back_stat_t;

  // Smaller value wins; equal values go to the higher leaf position.
  function automatic logic wins(node_t a, node_t b);
    if (a.value != b.value) begin
      return a.value < b.value;
    end
    return a.pos > b.pos;
  endfunction

  // Highest leaf position below a node: extend the index with ones down to leaf level.
  function automatic logic [POS_W-1:0] reset_pos(logic [NODE_W-1:0] idx);
    logic [NODE_W-1:0] msb;
    logic [NODE_W-1:0] shift;
    logic [NODE_W-1:0] fill;
    logic [NODE_W-1:0] ext;
    msb = '0;
    for (int j = 0; j < NODE_W; j++) begin
      if (idx[j]) begin
        msb = NODE_W'(j);
      end
    end
    shift = NODE_W'(LOG2_LEAVES) - msb;
    fill  = (NODE_W'(1) << shift) - NODE_W'(1);
    ext   = (idx << shift) | fill;
    return POS_W'(ext[LOG2_LEAVES-1:0]);
  endfunction

endpackage
`default_nettype wire

FILE: src/mstam_front.sv
`default_nettype none
module mstam_front (
  input  wire logic [mstam_pkg::OP_W-1:0]         operation,
  input  wire logic [mstam_pkg::POS_W-1:0]        position,
  input  wire logic signed [mstam_pkg::VAL_W-1:0] value,
  input  wire logic [mstam_pkg::END_W-1:0]        range_end,
  output mstam_pkg::cmd_t                         cmd
);
  import mstam_pkg::*;

  logic [BOUND_W-1:0] pos_ext;
  logic [BOUND_W-1:0] end_ext;
  logic [BOUND_W-1:0] end_clamp;

  always_comb begin
    pos_ext   = BOUND_W'(position);
    end_ext   = BOUND_W'(range_end);
    end_clamp = (end_ext > BOUND_W'(LEAVES)) ? BOUND_W'(LEAVES) : end_ext;

    cmd.op     = (operation == OP_WRITE || operation == OP_QUERY) ? operation : OP_READ;
    cmd.pos    = position;
    cmd.value  = value;
    cmd.lo     = pos_ext + BOUND_W'(LEAVES);
    cmd.hi     = end_clamp + BOUND_W'(LEAVES);
    cmd.pos_ok = pos_ext < BOUND_W'(LEAVES);
    cmd.empty  = pos_ext >= end_clamp;
  end

endmodule
`default_nettype wire

FILE: src/mstam_queue.sv
`default_nettype none
module mstam_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire mstam_pkg::cmd_t wr_data,
  output logic                 q_full,
  input  wire logic            rd_en,
  output mstam_pkg::cmd_t      rd_data,
  output logic                 q_valid
);
  import mstam_pkg::*;

  cmd_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QPTR_W-1:0] wp_nxt;
  logic [QPTR_W-1:0] rp_nxt;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign q_valid = cnt_r != '0;
  assign rd_data = slots_r[rp_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + QPTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + QPTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: src/mstam_back.sv
`default_nettype none
module mstam_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_valid,
  input  wire mstam_pkg::cmd_t                    q_data,
  output logic                                    q_pop,
  input  wire logic                               out_pop,
  output logic                                    out_valid,
  output logic signed [mstam_pkg::VAL_W-1:0]      res_value,
  output logic [mstam_pkg::POS_W-1:0]             res_position,
  output logic                                    res_empty,
  output logic signed [mstam_pkg::VAL_W-1:0]      gmin_value,
  output logic [mstam_pkg::POS_W-1:0]             gmin_position,
  output mstam_pkg::back_stat_t                   stat
);
  import mstam_pkg::*;

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_INIT = 3'd0;
  localparam logic [STATE_W-1:0] S_IDLE = 3'd1;
  localparam logic [STATE_W-1:0] S_UP   = 3'd2;
  localparam logic [STATE_W-1:0] S_QRY  = 3'd3;
  localparam logic [STATE_W-1:0] S_RD   = 3'd4;
  localparam logic [STATE_W-1:0] S_DONE = 3'd5;

  node_t mem [NODES];
  node_t rd_a_r;
  node_t rd_b_r;

  logic [STATE_W-1:0] state_r, state_nxt;
  logic [NODE_W-1:0]  init_cnt_r, init_cnt_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [NODE_W-1:0]  p_r, p_nxt;
  node_t              cur_r, cur_nxt;
  logic [BOUND_W-1:0] l_r, l_nxt;
  logic [BOUND_W-1:0] r_r, r_nxt;
  logic               va_r, va_nxt;
  logic               vb_r, vb_nxt;
  node_t              acc_r, acc_nxt;
  logic               have_r, have_nxt;
  node_t              res_r, res_nxt;
  logic               res_empty_r, res_empty_nxt;
  node_t              gmin_r, gmin_nxt;
  logic               out_valid_r, out_valid_nxt;
  node_t              out_r, out_nxt;
  logic               out_empty_r, out_empty_nxt;
  node_t              out_g_r, out_g_nxt;

  logic               we;
  logic [NODE_W-1:0]  wa;
  node_t              wd;
  logic               ra_en;
  logic [NODE_W-1:0]  ra_addr;
  logic               rb_en;
  logic [NODE_W-1:0]  rb_addr;

  node_t              fold;
  logic               fold_have;
  node_t              left_n;
  node_t              right_n;
  node_t              par;
  logic [NODE_W-1:0]  parent;
  logic [BOUND_W-1:0] r_m1;
  logic               take;

  // Folds the node minima read in the previous cycle into the running range minimum.
  always_comb begin
    fold      = acc_r;
    fold_have = have_r;
    if (va_r && (!fold_have || wins(rd_a_r, fold))) begin
      fold      = rd_a_r;
      fold_have = 1'b1;
    end
    if (vb_r && (!fold_have || wins(rd_b_r, fold))) begin
      fold      = rd_b_r;
      fold_have = 1'b1;
    end
  end

  always_comb begin
    left_n  = p_r[0] ? rd_a_r : cur_r;
    right_n = p_r[0] ? cur_r : rd_a_r;
    par     = wins(left_n, right_n) ? left_n : right_n;
    parent  = p_r >> 1;
    r_m1    = r_r - BOUND_W'(1);
  end

  assign take = (state_r == S_DONE) && (!out_valid_r || out_pop);

  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    cmd_nxt       = cmd_r;
    p_nxt         = p_r;
    cur_nxt       = cur_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    va_nxt        = 1'b0;
    vb_nxt        = 1'b0;
    acc_nxt       = acc_r;
    have_nxt      = have_r;
    res_nxt       = res_r;
    res_empty_nxt = res_empty_r;
    gmin_nxt      = gmin_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;
    ra_en         = 1'b0;
    ra_addr       = '0;
    rb_en         = 1'b0;
    rb_addr       = '0;

    unique case (state_r)
      S_INIT: begin
        we           = 1'b1;
        wa           = init_cnt_r;
        wd.value     = VAL_MAX;
        wd.pos       = reset_pos(init_cnt_r);
        init_cnt_nxt = init_cnt_r + NODE_W'(1);
        if (init_cnt_r == NODE_W'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        res_empty_nxt = 1'b0;
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          unique case (q_data.op)
            OP_WRITE: begin
              if (q_data.pos_ok) begin
                we       = 1'b1;
                wa       = q_data.lo[NODE_W-1:0];
                wd.value = q_data.value;
                wd.pos   = q_data.pos;
                cur_nxt  = wd;
                p_nxt    = q_data.lo[NODE_W-1:0];
                ra_en    = 1'b1;
                ra_addr  = q_data.lo[NODE_W-1:0] ^ NODE_W'(1);
                state_nxt = S_UP;
              end else begin
                res_nxt.value = q_data.value;
                res_nxt.pos   = q_data.pos;
                state_nxt     = S_DONE;
              end
            end
            OP_QUERY: begin
              if (q_data.empty) begin
                res_nxt.value = VAL_MAX;
                res_nxt.pos   = '0;
                res_empty_nxt = 1'b1;
                state_nxt     = S_DONE;
              end else begin
                l_nxt         = q_data.lo;
                r_nxt         = q_data.hi;
                acc_nxt.value = VAL_MAX;
                acc_nxt.pos   = '0;
                have_nxt      = 1'b0;
                state_nxt     = S_QRY;
              end
            end
            default: begin
              if (q_data.pos_ok) begin
                ra_en     = 1'b1;
                ra_addr   = q_data.lo[NODE_W-1:0];
                state_nxt = S_RD;
              end else begin
                res_nxt.value = VAL_MAX;
                res_nxt.pos   = q_data.pos;
                state_nxt     = S_DONE;
              end
            end
          endcase
        end
      end
      S_UP: begin
        we      = 1'b1;
        wa      = parent;
        wd      = par;
        cur_nxt = par;
        p_nxt   = parent;
        if (parent == NODE_W'(1)) begin
          gmin_nxt      = par;
          res_nxt.value = cmd_r.value;
          res_nxt.pos   = cmd_r.pos;
          state_nxt     = S_DONE;
        end else begin
          ra_en   = 1'b1;
          ra_addr = parent ^ NODE_W'(1);
        end
      end
      S_QRY: begin
        acc_nxt  = fold;
        have_nxt = fold_have;
        if (l_r < r_r) begin
          ra_en   = l_r[0];
          ra_addr = l_r[NODE_W-1:0];
          rb_en   = r_r[0];
          rb_addr = r_m1[NODE_W-1:0];
          va_nxt  = l_r[0];
          vb_nxt  = r_r[0];
          l_nxt   = (l_r + BOUND_W'(l_r[0])) >> 1;
          r_nxt   = r_r >> 1;
        end else begin
          res_nxt   = fold;
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        res_nxt.value = rd_a_r.value;
        res_nxt.pos   = cmd_r.pos;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    out_empty_nxt = out_empty_r;
    out_g_nxt     = out_g_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res_r;
      out_empty_nxt = res_empty_r;
      out_g_nxt     = gmin_r;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_cnt_r   <= '0;
      va_r         <= 1'b0;
      vb_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      gmin_r.value <= VAL_MAX;
      gmin_r.pos   <= POS_W'(LEAVES - 1);
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      out_valid_r <= out_valid_nxt;
      gmin_r      <= gmin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    p_r         <= p_nxt;
    cur_r       <= cur_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    acc_r       <= acc_nxt;
    have_r      <= have_nxt;
    res_r       <= res_nxt;
    res_empty_r <= res_empty_nxt;
    out_r       <= out_nxt;
    out_empty_r <= out_empty_nxt;
    out_g_r     <= out_g_nxt;
  end

  // Tree storage: one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ra_en) begin
      rd_a_r <= mem[ra_addr];
    end
    if (rb_en) begin
      rd_b_r <= mem[rb_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign res_value     = out_r.value;
  assign res_position  = out_r.pos;
  assign res_empty     = out_empty_r;
  assign gmin_value    = out_g_r.value;
  assign gmin_position = out_g_r.pos;
  assign stat.init     = state_r == S_INIT;
  assign stat.idle     = state_r == S_IDLE;
  assign stat.take     = take;

endmodule
`default_nettype wire

FILE: src/min_segment_tree_argmin_top.sv
`default_nettype none
// Writes and queries walk the tree, one level per cycle, so their time from accept to result
// grows with the tree depth (LOG2_LEAVES); reads and empty queries do not walk the tree.
// One item is worked at a time: the next one starts only once the result has moved to the
// output slot; two more wait in the queue.
// Reset (synchronous, rst_n low) clears control state, then a clearing pass writes all
// 2*LEAVES tree nodes with full held high before the first item is taken.
`include "assert_macros.svh"
module min_segment_tree_argmin_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [mstam_pkg::OP_W-1:0]         in_operation,
  input  wire logic [mstam_pkg::POS_W-1:0]        in_position,
  input  wire logic signed [mstam_pkg::VAL_W-1:0] in_value,
  input  wire logic [mstam_pkg::END_W-1:0]        in_range_end,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic signed [mstam_pkg::VAL_W-1:0]      out_result_value,
  output logic [mstam_pkg::POS_W-1:0]             out_result_position,
  output logic                                    out_range_empty,
  output logic signed [mstam_pkg::VAL_W-1:0]      out_global_min_value,
  output logic [mstam_pkg::POS_W-1:0]             out_global_min_position
);
  import mstam_pkg::*;

  cmd_t       front_cmd;
  cmd_t       q_data;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       out_valid;
  back_stat_t stat;

  assign full  = q_full || stat.init;
  assign empty = !out_valid;

  mstam_front u_front (
    .operation (in_operation),
    .position  (in_position),
    .value     (in_value),
    .range_end (in_range_end),
    .cmd       (front_cmd)
  );

  mstam_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push && !full),
    .wr_data (front_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_valid (q_valid)
  );

  mstam_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_pop       (pop),
    .out_valid     (out_valid),
    .res_value     (out_result_value),
    .res_position  (out_result_position),
    .res_empty     (out_range_empty),
    .gmin_value    (out_global_min_value),
    .gmin_position (out_global_min_position),
    .stat          (stat)
  );

  // No item leaves the queue while the tree is being cleared.
  `MSTAM_ASSERT(a_no_take_during_init, clk, rst_n, stat.init |-> !q_pop)
  // Taking an item always moves the back end out of idle.
  `MSTAM_ASSERT(a_pop_leaves_idle, clk, rst_n, q_pop |=> !stat.idle)
  // A result is loaded only into a free or draining output slot.
  `MSTAM_ASSERT(a_take_slot_free, clk, rst_n, stat.take |-> (empty || pop))
  // An empty range always reports the maximum value at position zero.
  `MSTAM_ASSERT(a_empty_range_result, clk, rst_n,
    (!empty && out_range_empty) |-> (out_result_position == '0 && out_result_value == VAL_MAX))

endmodule
`default_nettype wire
